// ===== hw/rtl/ncm_pkg.sv =====
`timescale 1ns / 1ps
package ncm_pkg;

   localparam int PHASE_BITS              = 32;
   localparam int SAMPLE_BITS             = 16;
   localparam int TABLE_ADDR_BITS_DEFAULT = 10;
   localparam int PROD_BITS               = 2 * SAMPLE_BITS;
   localparam int ACC_BITS                = PROD_BITS + 1;
   localparam int SAMPLE_MAX              = 2 ** (SAMPLE_BITS - 1) - 1;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int MODE_BITS     = 3;
   localparam int ACTION_BITS   = 2;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic        [PHASE_BITS-1:0]  phase_type;
   typedef logic signed [PHASE_BITS-1:0]  incr_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;
   typedef logic        [ACTION_BITS-1:0] action_type;
   typedef logic        [MODE_BITS-1:0]   mode_type;

   localparam action_type ACT_SAMPLE    = 2'd0;
   localparam action_type ACT_PHASE     = 2'd1;
   localparam action_type ACT_INCREMENT = 2'd2;

   localparam mode_type MODE_OSC          = 3'd0;
   localparam mode_type MODE_COMPLEX      = 3'd1;
   localparam mode_type MODE_REAL_COMPLEX = 3'd2;
   localparam mode_type MODE_REAL_REAL    = 3'd3;
   localparam mode_type MODE_COMPLEX_REAL = 3'd4;

   localparam logic REG_PHASE_INCREMENT = 1'b0;
   localparam logic REG_MIX_MODE        = 1'b1;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

   // Quarter-wave sine entry q of a 2^tab_bits table, Q30 Taylor series to x^15.
   function automatic logic [SAMPLE_BITS-2:0] quarter_sine(input int unsigned q,
                                                           input int unsigned tab_bits);
      logic [63:0]        x;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] scaled;
      x = (HALF_PI_Q30 * 64'(q) + (64'd1 << (tab_bits - 3))) >> (tab_bits - 2);
      term = x;
      sum = $signed(x);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd6;
      sum = sum - $signed(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd20;
      sum = sum + $signed(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd42;
      sum = sum - $signed(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd72;
      sum = sum + $signed(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd110;
      sum = sum - $signed(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd156;
      sum = sum + $signed(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd210;
      sum = sum - $signed(term);
      if (sum < 0) sum = 0;
      if (sum > ONE_Q30) sum = ONE_Q30;
      scaled = (sum * 64'(SAMPLE_MAX) + (ONE_Q30 >>> 1)) >>> 30;
      return scaled[SAMPLE_BITS-2:0];
   endfunction

endpackage

// ===== hw/rtl/ncm_req_if.sv =====
`timescale 1ns / 1ps
interface ncm_req_if;
   import ncm_pkg::*;

   logic       valid;
   logic       ready;
   action_type action;
   sample_type in_re;
   sample_type in_im;
   incr_type   adjust_value;

   modport source (output valid, action, in_re, in_im, adjust_value, input ready);
   modport sink   (input valid, action, in_re, in_im, adjust_value, output ready);
endinterface

// ===== hw/rtl/ncm_rsp_if.sv =====
`timescale 1ns / 1ps
interface ncm_rsp_if;
   import ncm_pkg::*;

   logic       valid;
   logic       ready;
   sample_type out_re;
   sample_type out_im;
   phase_type  phase_now;
   incr_type   increment_now;

   modport source (output valid, out_re, out_im, phase_now, increment_now, input ready);
   modport sink   (input valid, out_re, out_im, phase_now, increment_now, output ready);
endinterface

// ===== hw/rtl/ncm_sincos_rom.sv =====
`timescale 1ns / 1ps
module ncm_sincos_rom #(
   parameter int TABLE_ADDR_BITS = ncm_pkg::TABLE_ADDR_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [TABLE_ADDR_BITS-1:0] phase_idx,
   output ncm_pkg::sample_type        cos_value,
   output ncm_pkg::sample_type        sin_value
);
   import ncm_pkg::*;

   localparam int QUARTER_SIZE  = 2 ** (TABLE_ADDR_BITS - 2);
   localparam int ROM_ADDR_BITS = TABLE_ADDR_BITS - 1;

   typedef logic [SAMPLE_BITS-2:0] entry_type;

   entry_type                  rom_table [QUARTER_SIZE+1];
   logic [TABLE_ADDR_BITS-1:0] cos_idx;
   logic [ROM_ADDR_BITS-1:0]   cos_addr;
   logic [ROM_ADDR_BITS-1:0]   sin_addr;
   entry_type                  cos_data_ff;
   entry_type                  sin_data_ff;
   logic                       cos_neg_in, cos_neg_ff;
   logic                       sin_neg_in, sin_neg_ff;
   sample_type                 cos_mag;
   sample_type                 sin_mag;

   for (genvar q = 0; q <= QUARTER_SIZE; q++) begin : g_rom
      assign rom_table[q] = quarter_sine(q, TABLE_ADDR_BITS);
   end

   // cosine is sine a quarter turn ahead
   assign cos_idx = phase_idx + TABLE_ADDR_BITS'(QUARTER_SIZE);

   // fold the index into the quarter wave; odd quadrants mirror, upper half negates
   always_comb begin
      cos_addr = cos_idx[TABLE_ADDR_BITS-2] ?
                 ROM_ADDR_BITS'(QUARTER_SIZE) - ROM_ADDR_BITS'(cos_idx[TABLE_ADDR_BITS-3:0]) :
                 ROM_ADDR_BITS'(cos_idx[TABLE_ADDR_BITS-3:0]);
      sin_addr = phase_idx[TABLE_ADDR_BITS-2] ?
                 ROM_ADDR_BITS'(QUARTER_SIZE) - ROM_ADDR_BITS'(phase_idx[TABLE_ADDR_BITS-3:0]) :
                 ROM_ADDR_BITS'(phase_idx[TABLE_ADDR_BITS-3:0]);
      cos_neg_in  = cos_idx[TABLE_ADDR_BITS-1];
      sin_neg_in  = phase_idx[TABLE_ADDR_BITS-1];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cos_data_ff <= rom_table[cos_addr];
         sin_data_ff <= rom_table[sin_addr];
         cos_neg_ff  <= cos_neg_in;
         sin_neg_ff  <= sin_neg_in;
      end
   end

   assign cos_mag   = sample_type'({1'b0, cos_data_ff});
   assign sin_mag   = sample_type'({1'b0, sin_data_ff});
   assign cos_value = cos_neg_ff ? -cos_mag : cos_mag;
   assign sin_value = sin_neg_ff ? -sin_mag : sin_mag;
endmodule

// ===== hw/rtl/nco_complex_mixer.sv =====
`timescale 1ns / 1ps
// Quadrature NCO and mixer. The block takes one transaction per clock unless the result
// side holds back, and returns one result per transaction through the stage 1, stage 2
// and stage 3 registers; the sustained rate is set by the phase accumulator and running
// increment updating on each acceptance, and by the dual-read sine table, which serves
// cosine and sine in the same cycle. The phase counts in 2^-32 turn and wraps freely;
// the top TABLE_ADDR_BITS phase bits address a quarter-wave Q1.15 table (truncation,
// no interpolation). A sample transaction returns the oscillator or mixes it with the
// input per mix_mode (0 oscillator, 1 conjugate complex, 2 real to complex, 3 real only,
// 4 complex to real; codes 5 to 7 act as 0), rounding half up and saturating to 16 bits,
// then advances the phase by the running increment. Action 1 adds adjust_value to the
// phase, action 2 adds it to the running increment, which drops to zero when the sum
// passes half a turn; action 3 changes nothing. Adjust transactions return zero samples.
// Every result carries the phase and increment after its transaction. Writing
// phase_increment (byte address 0) reloads the running increment; mix_mode sits at
// byte address 4. Write registers only while no transaction is in flight.
module nco_complex_mixer #(
   parameter int TABLE_ADDR_BITS = ncm_pkg::TABLE_ADDR_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   ncm_req_if.sink                           req_chan,
   ncm_rsp_if.source                         rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ncm_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [ncm_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [ncm_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import ncm_pkg::*;

   localparam logic signed [PHASE_BITS:0] HALF_TURN = (PHASE_BITS + 1)'(1) << (PHASE_BITS - 1);
   localparam logic signed [ACC_BITS:0] ROUND_BIAS = (ACC_BITS + 1)'(1) << (SAMPLE_BITS - 2);
   localparam logic signed [ACC_BITS:0] SAT_MAX = (ACC_BITS + 1)'(SAMPLE_MAX);
   localparam logic signed [ACC_BITS:0] SAT_MIN = -SAT_MAX - (ACC_BITS + 1)'(1);

   // configuration and state
   incr_type  phase_increment_in, phase_increment_ff;
   mode_type  mix_mode_in, mix_mode_ff;
   phase_type phase_acc_in, phase_acc_ff;
   incr_type  running_inc_in, running_inc_ff;

   logic                    csr_write;
   logic                    csr_index;
   logic signed [PHASE_BITS:0] inc_sum;

   // pipeline control
   logic en1, en2, en3;
   logic req_fire;
   logic v1_in, v1_ff, v2_in, v2_ff, v3_in, v3_ff;

   // stage 1: table read in flight
   action_type act1_ff;
   sample_type re1_ff, im1_ff;
   phase_type  phase1_ff;
   incr_type   inc1_ff;
   sample_type cos1, sin1;

   // stage 2: products
   action_type act2_ff;
   phase_type  phase2_ff;
   incr_type   inc2_ff;
   sample_type cos2_ff, sin2_ff;
   prod_type   pcr_in, pcr_ff, psi_in, psi_ff, pci_in, pci_ff, psr_in, psr_ff;

   // stage 3: output register
   sample_type out_re_in, out_re_ff, out_im_in, out_im_ff;
   phase_type  phase3_ff;
   incr_type   inc3_ff;
   acc_type    sum_a, diff_b;

   function automatic sample_type round_sat(input acc_type v);
      logic signed [ACC_BITS:0] t;
      t = ((ACC_BITS + 1)'(v) + ROUND_BIAS) >>> (SAMPLE_BITS - 1);
      if (t > SAT_MAX) return sample_type'(SAT_MAX);
      if (t < SAT_MIN) return sample_type'(SAT_MIN);
      return sample_type'(t);
   endfunction

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[CSR_ADDR_BITS-1];

   always_comb begin
      unique case (csr_index)
         REG_PHASE_INCREMENT: csr_prdata = CSR_DATA_BITS'(phase_increment_ff);
         REG_MIX_MODE:        csr_prdata = CSR_DATA_BITS'(mix_mode_ff);
         default:             csr_prdata = '0;
      endcase
   end

   always_comb begin
      phase_increment_in = phase_increment_ff;
      mix_mode_in        = mix_mode_ff;
      if (csr_write && csr_index == REG_PHASE_INCREMENT) begin
         phase_increment_in = incr_type'(csr_pwdata[PHASE_BITS-1:0]);
      end
      if (csr_write && csr_index == REG_MIX_MODE) begin
         mix_mode_in = csr_pwdata[MODE_BITS-1:0];
      end
   end

   // ---------------- handshake and stall chain ----------------
   // each stage moves when the one after it is empty or moving
   assign en3 = !v3_ff || rsp_chan.ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_chan.ready = en1;
   assign req_fire = req_chan.valid && en1;

   assign v1_in = en1 ? req_chan.valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;

   // ---------------- phase and increment update ----------------
   assign inc_sum = (PHASE_BITS + 1)'(running_inc_ff) + (PHASE_BITS + 1)'(req_chan.adjust_value);

   always_comb begin
      phase_acc_in   = phase_acc_ff;
      running_inc_in = running_inc_ff;
      if (req_fire) begin
         unique case (req_chan.action)
            ACT_SAMPLE:    phase_acc_in = phase_acc_ff + phase_type'(running_inc_ff);
            ACT_PHASE:     phase_acc_in = phase_acc_ff + phase_type'(req_chan.adjust_value);
            ACT_INCREMENT: begin
               // drop a step past half a turn; exactly half a turn wraps to minus half
               if (inc_sum > HALF_TURN || inc_sum < -HALF_TURN) begin
                  running_inc_in = '0;
               end else begin
                  running_inc_in = incr_type'(inc_sum[PHASE_BITS-1:0]);
               end
            end
            default: ;
         endcase
      end
      // a register write reloads the running increment
      if (csr_write && csr_index == REG_PHASE_INCREMENT) begin
         running_inc_in = incr_type'(csr_pwdata[PHASE_BITS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_increment_ff <= '0;
         mix_mode_ff        <= MODE_COMPLEX;
         phase_acc_ff       <= '0;
         running_inc_ff     <= '0;
         v1_ff              <= 1'b0;
         v2_ff              <= 1'b0;
         v3_ff              <= 1'b0;
      end else begin
         phase_increment_ff <= phase_increment_in;
         mix_mode_ff        <= mix_mode_in;
         phase_acc_ff       <= phase_acc_in;
         running_inc_ff     <= running_inc_in;
         v1_ff              <= v1_in;
         v2_ff              <= v2_in;
         v3_ff              <= v3_in;
      end
   end

   // ---------------- stage 1: table read at the phase before the step ----------------
   ncm_sincos_rom #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_rom (
      .clock     (clock),
      .enable    (en1),
      .phase_idx (phase_acc_ff[PHASE_BITS-1 -: TABLE_ADDR_BITS]),
      .cos_value (cos1),
      .sin_value (sin1)
   );

   always_ff @(posedge clock) begin
      if (en1) begin
         act1_ff   <= req_chan.action;
         re1_ff    <= req_chan.in_re;
         im1_ff    <= req_chan.in_im;
         phase1_ff <= phase_acc_in;
         inc1_ff   <= running_inc_in;
      end
   end

   // ---------------- stage 2: multiply ----------------
   assign pcr_in = cos1 * re1_ff;
   assign psi_in = sin1 * im1_ff;
   assign pci_in = cos1 * im1_ff;
   assign psr_in = sin1 * re1_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         act2_ff   <= act1_ff;
         phase2_ff <= phase1_ff;
         inc2_ff   <= inc1_ff;
         cos2_ff   <= cos1;
         sin2_ff   <= sin1;
         pcr_ff    <= pcr_in;
         psi_ff    <= psi_in;
         pci_ff    <= pci_in;
         psr_ff    <= psr_in;
      end
   end

   // ---------------- stage 3: combine, round, saturate ----------------
   assign sum_a  = acc_type'(pcr_ff) + acc_type'(psi_ff);
   assign diff_b = acc_type'(pci_ff) - acc_type'(psr_ff);

   always_comb begin
      unique case (mix_mode_ff)
         MODE_COMPLEX: begin
            out_re_in = round_sat(sum_a);
            out_im_in = round_sat(diff_b);
         end
         MODE_REAL_COMPLEX: begin
            out_re_in = round_sat(acc_type'(pcr_ff));
            out_im_in = round_sat(acc_type'(psr_ff));
         end
         MODE_REAL_REAL: begin
            out_re_in = round_sat(acc_type'(pcr_ff));
            out_im_in = '0;
         end
         MODE_COMPLEX_REAL: begin
            out_re_in = round_sat(sum_a);
            out_im_in = '0;
         end
         default: begin
            // oscillator only, also for unused mode codes
            out_re_in = cos2_ff;
            out_im_in = sin2_ff;
         end
      endcase
      if (act2_ff != ACT_SAMPLE) begin
         out_re_in = '0;
         out_im_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         out_re_ff <= out_re_in;
         out_im_ff <= out_im_in;
         phase3_ff <= phase2_ff;
         inc3_ff   <= inc2_ff;
      end
   end

   assign rsp_chan.valid         = v3_ff;
   assign rsp_chan.out_re        = out_re_ff;
   assign rsp_chan.out_im        = out_im_ff;
   assign rsp_chan.phase_now     = phase3_ff;
   assign rsp_chan.increment_now = inc3_ff;

   // ---------------- assertions ----------------
   a_cfg_reload: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_index == REG_PHASE_INCREMENT)
      |=> (running_inc_ff == incr_type'($past(csr_pwdata[PHASE_BITS-1:0]))))
      else $error("running increment not reloaded by register write");

   a_phase_step: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.action == ACT_SAMPLE)
      |=> (phase_acc_ff == $past(phase_acc_ff + phase_type'(running_inc_ff))))
      else $error("phase did not advance by the running increment");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (v1_ff && v2_ff && v3_ff && !rsp_chan.ready))
      else $error("input stalled while the pipeline has room");
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import ncm_pkg::*;

   // Codes the package leaves unnamed: action 3 changes nothing, mode 7 acts as the
   // bare oscillator.
   localparam action_type ACT_NONE   = 2'd3;
   localparam mode_type   MODE_SPARE = 3'd7;

   localparam int     TAB_BITS       = TABLE_ADDR_BITS_DEFAULT;
   localparam int     QUARTER        = 1 << (TAB_BITS - 2);
   localparam longint HALF_TURN      = 64'sd1 <<< (PHASE_BITS - 1);
   localparam int     IDLE_PCT       = 28;
   localparam int     WATCHDOG_LIMIT = 5000;
   localparam int     PHASE_COUNT    = 8;
   localparam int     ITEMS_PER_PHASE = 200;

   typedef struct packed {
      action_type action;
      sample_type in_re;
      sample_type in_im;
      incr_type   adjust_value;
   } mix_request_t;

   typedef struct packed {
      sample_type out_re;
      sample_type out_im;
      phase_type  phase_now;
      incr_type   increment_now;
   } mix_result_t;

   // One line of the directed drill: either a register write or a transaction, the
   // latter optionally with its result typed in by hand.
   typedef struct packed {
      bit           is_write;
      logic         reg_sel;
      logic [31:0]  reg_value;
      mix_request_t rq;
      bit           pinned;
      mix_result_t  res;
   } drill_row_t;

   logic clock = 1'b0;
   logic reset;

   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   ncm_req_if req_bus ();
   ncm_rsp_if rsp_bus ();

   nco_complex_mixer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // Shadow of the block: quarter-wave table, phase accumulator, running step, mode.
   longint      quarter_wave [0:QUARTER];
   phase_type   osc_phase;
   incr_type    osc_step;
   mode_type    mix_sel;

   mix_result_t results_due [$];
   drill_row_t  drill [$];
   int          mismatches = 0;
   bit          calm = 1'b0;   // when set, neither side idles
   int          stuck_cycles = 0;

   // Entry q of the quarter wave: sine of (q / QUARTER) * pi/2 by a Q30 Taylor series
   // up to x^15, each term truncated, then scaled to the sample amplitude.
   function automatic longint taylor_sine(input int unsigned q);
      longint unsigned x;
      longint unsigned term;
      longint          acc;
      int              n;
      x = (HALF_PI_Q30 * 64'(q) + (64'd1 << (TAB_BITS - 3))) >> (TAB_BITS - 2);
      term = x;
      acc = longint'(x);
      for (n = 1; n <= 7; n++) begin
         term = ((term * x) >> 30) * x >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) acc = acc - longint'(term);
         else            acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
      return (acc * SAMPLE_MAX + (64'sd1 <<< 29)) >>> 30;
   endfunction

   // Full-circle lookup: mirror within odd quadrants, negate in the upper half.
   function automatic longint wave_at(input logic [TAB_BITS-1:0] k);
      int unsigned r;
      longint      v;
      r = 32'(k[TAB_BITS-3:0]);
      v = k[TAB_BITS-2] ? quarter_wave[QUARTER - r] : quarter_wave[r];
      return k[TAB_BITS-1] ? -v : v;
   endfunction

   // Round half up from a Q2.30 product to Q1.15, then clamp.
   function automatic sample_type to_sample(input longint v);
      longint t;
      t = (v + (64'sd1 <<< (SAMPLE_BITS - 2))) >>> (SAMPLE_BITS - 1);
      if (t > SAMPLE_MAX)      t = SAMPLE_MAX;
      else if (t < -SAMPLE_MAX - 1) t = -SAMPLE_MAX - 1;
      return sample_type'(t);
   endfunction

   // A step beyond half a turn either way collapses to zero; exactly +half wraps to -half.
   function automatic incr_type clip_step(input longint v);
      if (v > HALF_TURN || v < -HALF_TURN) return '0;
      return incr_type'(v);
   endfunction

   // Apply one transaction to the shadow state and return the result it produces.
   function automatic mix_result_t mix_and_advance(input mix_request_t rq);
      mix_result_t         res;
      logic [TAB_BITS-1:0] k;
      logic [TAB_BITS-1:0] kc;
      longint              c;
      longint              s;
      longint              r;
      longint              i;
      res = '0;
      r = longint'(rq.in_re);
      i = longint'(rq.in_im);
      case (rq.action)
         ACT_SAMPLE: begin
            k  = osc_phase[PHASE_BITS-1 -: TAB_BITS];
            kc = k + TAB_BITS'(QUARTER);
            c  = wave_at(kc);
            s  = wave_at(k);
            case (mix_sel)
               MODE_COMPLEX: begin
                  res.out_re = to_sample(c * r + s * i);
                  res.out_im = to_sample(c * i - s * r);
               end
               MODE_REAL_COMPLEX: begin
                  res.out_re = to_sample(c * r);
                  res.out_im = to_sample(s * r);
               end
               MODE_REAL_REAL: begin
                  res.out_re = to_sample(c * r);
               end
               MODE_COMPLEX_REAL: begin
                  res.out_re = to_sample(c * r + s * i);
               end
               default: begin
                  res.out_re = sample_type'(c);
                  res.out_im = sample_type'(s);
               end
            endcase
            osc_phase = osc_phase + phase_type'(osc_step);
         end
         ACT_PHASE: osc_phase = osc_phase + phase_type'(rq.adjust_value);
         ACT_INCREMENT: osc_step = clip_step(longint'(osc_step) + longint'(rq.adjust_value));
         default: ;
      endcase
      res.phase_now     = osc_phase;
      res.increment_now = osc_step;
      return res;
   endfunction

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 11))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic void add_send(input mix_request_t rq, input bit pinned,
                                    input mix_result_t res);
      drill.push_back('{1'b0, 1'b0, 32'd0, rq, pinned, res});
   endfunction

   function automatic void add_write(input logic sel, input logic [31:0] value);
      drill.push_back('{1'b1, sel, value, mix_request_t'('0), 1'b0, mix_result_t'('0)});
   endfunction

   function automatic void check_field(input string what, input longint want, input longint got);
      if (want != got) begin
         mismatches++;
         $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
      end
   endfunction

   // Drop valid and wait until every result in flight has been taken.
   task automatic settle();
      if (req_bus.valid) req_bus.valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
   endtask

   // Offer one transaction, idling first at random; record its result on acceptance.
   task automatic send_request(input mix_request_t rq, input bit pinned,
                               input mix_result_t pinned_res);
      mix_result_t res;
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.action       <= rq.action;
      req_bus.in_re        <= rq.in_re;
      req_bus.in_im        <= rq.in_im;
      req_bus.adjust_value <= rq.adjust_value;
      do @(posedge clock); while (!req_bus.ready);
      res = mix_and_advance(rq);
      results_due.push_back(pinned ? pinned_res : res);
   endtask

   // APB write: setup, access until pready, then back to idle on the bus.
   task automatic write_csr(input logic sel, input logic [31:0] value);
      settle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (sel == REG_PHASE_INCREMENT) osc_step = clip_step(longint'($signed(value)));
      else                            mix_sel  = value[MODE_BITS-1:0];
      @(posedge clock);
   endtask

   // Result side: take each transaction the block returns and compare it with the
   // oldest result still due; stall at random except during the calm stretch.
   initial begin
      mix_result_t want;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (results_due.size() == 0) begin
               mismatches++;
               $display("%0t unexpected result: expected none, got re %0d im %0d", $time,
                        rsp_bus.out_re, rsp_bus.out_im);
            end else begin
               want = results_due.pop_front();
               check_field("out_re", longint'(want.out_re), longint'(rsp_bus.out_re));
               check_field("out_im", longint'(want.out_im), longint'(rsp_bus.out_im));
               check_field("phase_now", longint'(want.phase_now), longint'(rsp_bus.phase_now));
               check_field("increment_now", longint'(want.increment_now),
                           longint'(rsp_bus.increment_now));
            end
         end
         rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Watchdog: end the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == WATCHDOG_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      mix_request_t rq;
      logic [31:0]  value;
      int           roll;
      int           ph;
      int           sent;

      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.action       = ACT_SAMPLE;
      req_bus.in_re        = '0;
      req_bus.in_im        = '0;
      req_bus.adjust_value = '0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;

      for (int q = 0; q <= QUARTER; q++) quarter_wave[q] = taylor_sine(q);
      osc_phase = '0;
      osc_step  = '0;
      mix_sel   = MODE_COMPLEX;

      // Directed drill. Out of reset: conjugate mix at phase zero, cosine full scale.
      add_send('{ACT_SAMPLE, 16'h8000, 16'h8000, 32'd0}, 1'b1,
               '{-16'sd32767, -16'sd32767, 32'h0, 32'h0});
      // unused action: nothing moves, zero samples
      add_send('{ACT_NONE, 16'h7FFF, 16'h7FFF, 32'h7FFFFFFF}, 1'b1, '{16'sd0, 16'sd0, 32'h0, 32'h0});
      // walk the running step up to exactly half a turn, then past the negative edge
      add_send('{ACT_INCREMENT, 16'h0, 16'h0, 32'h7FFFFFFF}, 1'b1,
               '{16'sd0, 16'sd0, 32'h0, 32'h7FFFFFFF});
      add_send('{ACT_INCREMENT, 16'h0, 16'h0, 32'h1}, 1'b1, '{16'sd0, 16'sd0, 32'h0, 32'h80000000});
      add_send('{ACT_INCREMENT, 16'h0, 16'h0, 32'hFFFFFFFF}, 1'b1, '{16'sd0, 16'sd0, 32'h0, 32'h0});
      add_send('{ACT_INCREMENT, 16'h0, 16'h0, 32'h80000000}, 1'b1,
               '{16'sd0, 16'sd0, 32'h0, 32'h80000000});
      add_send('{ACT_INCREMENT, 16'h0, 16'h0, 32'h80000000}, 1'b1, '{16'sd0, 16'sd0, 32'h0, 32'h0});
      // eighth turn: cosine equals sine, so mixing full scale saturates the real part
      add_send('{ACT_PHASE, 16'h0, 16'h0, 32'h20000000}, 1'b1,
               '{16'sd0, 16'sd0, 32'h20000000, 32'h0});
      add_send('{ACT_SAMPLE, 16'h7FFF, 16'h7FFF, 32'h0}, 1'b1,
               '{16'sd32767, 16'sd0, 32'h20000000, 32'h0});
      add_send('{ACT_SAMPLE, 16'h8000, 16'h8000, 32'h0}, 1'b1,
               '{16'sh8000, 16'sd0, 32'h20000000, 32'h0});
      add_send('{ACT_SAMPLE, 16'h8000, 16'h7FFF, 32'h0}, 1'b0, mix_result_t'('0));
      add_send('{ACT_PHASE, 16'h0, 16'h0, 32'hFFFFFFFF}, 1'b1,
               '{16'sd0, 16'sd0, 32'h1FFFFFFF, 32'h0});
      // bare oscillator stepping by a quarter turn around the circle
      add_write(REG_MIX_MODE, 32'(MODE_OSC));
      add_write(REG_PHASE_INCREMENT, 32'h40000000);
      add_send('{ACT_PHASE, 16'h0, 16'h0, 32'hE0000001}, 1'b1,
               '{16'sd0, 16'sd0, 32'h0, 32'h40000000});
      add_send('{ACT_SAMPLE, 16'h1234, 16'h4321, 32'h0}, 1'b1,
               '{16'sd32767, 16'sd0, 32'h40000000, 32'h40000000});
      add_send('{ACT_SAMPLE, 16'h0, 16'h0, 32'h0}, 1'b1,
               '{16'sd0, 16'sd32767, 32'h80000000, 32'h40000000});
      add_send('{ACT_SAMPLE, 16'h0, 16'h0, 32'h0}, 1'b1,
               '{-16'sd32767, 16'sd0, 32'hC0000000, 32'h40000000});
      add_send('{ACT_SAMPLE, 16'h0, 16'h0, 32'h0}, 1'b1,
               '{16'sd0, -16'sd32767, 32'h0, 32'h40000000});
      // real only at phase zero: a negative exact half rounds up
      add_write(REG_MIX_MODE, 32'(MODE_REAL_REAL));
      add_send('{ACT_SAMPLE, 16'hC000, 16'h7FFF, 32'h0}, 1'b1,
               '{-16'sd16383, 16'sd0, 32'h40000000, 32'h40000000});
      add_write(REG_MIX_MODE, 32'(MODE_REAL_COMPLEX));
      add_send('{ACT_SAMPLE, 16'h7FFF, 16'hFFFF, 32'h0}, 1'b0, mix_result_t'('0));
      add_write(REG_MIX_MODE, 32'(MODE_COMPLEX_REAL));
      add_send('{ACT_SAMPLE, 16'h8000, 16'h8000, 32'h0}, 1'b0, mix_result_t'('0));
      // step of minus half a turn, spare mode code
      add_write(REG_PHASE_INCREMENT, 32'h80000000);
      add_write(REG_MIX_MODE, 32'(MODE_SPARE));
      add_send('{ACT_SAMPLE, 16'h5555, 16'hAAAA, 32'h0}, 1'b0, mix_result_t'('0));
      add_send('{ACT_SAMPLE, 16'hAAAA, 16'h5555, 32'h0}, 1'b0, mix_result_t'('0));
      add_send('{ACT_NONE, 16'h8000, 16'h0, 32'h80000000}, 1'b0, mix_result_t'('0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (drill[n]) begin
         if (drill[n].is_write) write_csr(drill[n].reg_sel, drill[n].reg_value);
         else                   send_request(drill[n].rq, drill[n].pinned, drill[n].res);
      end

      // Random phases: each one sets a mode (all eight codes in turn) and a step,
      // then streams transactions with random content.
      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         value = $urandom;
         value[MODE_BITS-1:0] = mode_type'(ph);
         write_csr(REG_MIX_MODE, value);
         case (ph % 4)
            0: value = 32'h7FFFFFFF;
            1: value = 32'h80000000;
            2: value = $urandom_range(0, 1) ? 32'($urandom_range(0, 65535))
                                            : -32'($urandom_range(0, 65535));
            default: value = $urandom;
         endcase
         write_csr(REG_PHASE_INCREMENT, value);
         calm = (ph == 5);
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            roll = $urandom_range(0, 99);
            rq.action = (roll < 72) ? ACT_SAMPLE :
                        (roll < 84) ? ACT_PHASE :
                        (roll < 96) ? ACT_INCREMENT : ACT_NONE;
            rq.in_re = pick_sample();
            rq.in_im = pick_sample();
            rq.adjust_value = $urandom;
            // keep most step nudges small so the running step rarely collapses
            if (rq.action == ACT_INCREMENT && $urandom_range(0, 3) != 0)
               rq.adjust_value = $urandom_range(0, 1) ? 32'($urandom_range(0, 65535))
                                                      : -32'($urandom_range(0, 65535));
            if ($urandom_range(0, 15) == 0)
               rq.adjust_value = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            send_request(rq, 1'b0, mix_result_t'('0));
            if (rq.action != ACT_NONE) sent++;
         end
         calm = 1'b0;
      end

      settle();
      repeat (10) @(posedge clock);
      if (mismatches == 0) $display("tb: done, clean");
      else                 $display("tb: done, errors");
      $finish;
   end

endmodule
